// File: src/vra_pkg.sv
// shared types and constants for the vector register alu
`default_nettype none
package vra_pkg;

  localparam int unsigned MaxElementsDef = 64;

  localparam logic [3:0] OP_LOAD   = 4'd0;
  localparam logic [3:0] OP_SUM    = 4'd1;
  localparam logic [3:0] OP_NEGSUM = 4'd2;
  localparam logic [3:0] OP_PROD   = 4'd3;
  localparam logic [3:0] OP_DIV    = 4'd4;
  localparam logic [3:0] OP_ADDS   = 4'd5;
  localparam logic [3:0] OP_MULS   = 4'd6;
  localparam logic [3:0] OP_RDFWD  = 4'd7;
  localparam logic [3:0] OP_RDREV  = 4'd8;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_DIVZERO = 2'd1;
  localparam logic [1:0] ST_BADPOS  = 2'd2;
  localparam logic [1:0] ST_BADOP   = 2'd3;

  localparam logic [2:0] REG_ADDR_LEN = 3'd0;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_PUT,
    S_DA,
    S_DB,
    S_DV,
    S_RES
  } ctl_state_t;

  typedef enum logic [1:0] {
    D_IDLE,
    D_MAG,
    D_MUL,
    D_ITER
  } div_state_t;

  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [38:0] quotient;
  } div_rsp_t;

endpackage
`default_nettype wire

// File: src/vra_mem.sv
// element store: one write port, one read port, registered read data
`default_nettype none
module vra_mem #(
  parameter int unsigned DEPTH = vra_pkg::MaxElementsDef,
  parameter int unsigned AW    = 6
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [31:0]   wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [31:0]   rdata
);

  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// File: src/vra_div.sv
// rounded scaled divider, one quotient bit a cycle
`default_nettype none
module vra_div (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire vra_pkg::div_req_t  req,
  output vra_pkg::div_rsp_t       rsp
);

  vra_pkg::div_state_t st_r, st_nxt;
  logic [31:0] ma_r, mb_r;
  logic        neg_r;
  logic [39:0] num_r;
  logic [33:0] rem_r;
  logic [32:0] den_r;
  logic [5:0]  cnt_r;
  logic        done_r;
  logic [33:0] rem_sh;
  logic        fits;
  logic [38:0] q39;

  assign rem_sh = {rem_r[32:0], num_r[39]};
  assign fits   = rem_sh >= {1'b0, den_r};
  assign q39    = num_r[38:0];

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      vra_pkg::D_IDLE: if (req.start) st_nxt = vra_pkg::D_MAG;
      vra_pkg::D_MAG:  st_nxt = vra_pkg::D_MUL;
      vra_pkg::D_MUL:  st_nxt = vra_pkg::D_ITER;
      vra_pkg::D_ITER: if (cnt_r == 6'd39) st_nxt = vra_pkg::D_IDLE;
      default:         st_nxt = vra_pkg::D_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= vra_pkg::D_IDLE;
      done_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      done_r <= (st_r == vra_pkg::D_ITER) && (cnt_r == 6'd39);
    end
  end

  always_ff @(posedge clk) begin
    unique case (st_r)
      vra_pkg::D_IDLE: begin
        ma_r  <= req.dividend[31] ? (~req.dividend + 32'd1) : req.dividend;
        mb_r  <= req.divisor[31] ? (~req.divisor + 32'd1) : req.divisor;
        neg_r <= req.dividend[31] ^ req.divisor[31];
      end
      vra_pkg::D_MAG: begin
        // 2*a*100 + b, over 2*b
        num_r <= {8'd0, ma_r} * 40'd200 + {8'd0, mb_r};
        den_r <= {mb_r, 1'b0};
        rem_r <= '0;
        cnt_r <= '0;
      end
      vra_pkg::D_MUL: begin
      end
      vra_pkg::D_ITER: begin
        rem_r <= fits ? (rem_sh - {1'b0, den_r}) : rem_sh;
        num_r <= {num_r[38:0], fits};
        cnt_r <= cnt_r + 6'd1;
      end
      default: begin
      end
    endcase
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = neg_r ? (~q39 + 39'd1) : q39;

endmodule
`default_nettype wire

// File: src/vector_register_alu_top.sv
// vector register alu top level: request control, element walk, result register
// channel | ports                                  | direction
// request | in_valid/in_ready, in_* fields         | in
// result  | out_valid/out_ready, out_* fields      | out
// config  | cfg_psel/penable/pwrite/paddr/pwdata   | apb, pready tied high
// one request at a time; in_ready only while the controller is idle
// walks read one element a cycle from the store
// readouts give one word a cycle while the result side takes them
// divide: two element reads, then a run of the divider
// reset is synchronous; the length register returns to 64, elements are undefined
`default_nettype none
module vector_register_alu_top #(
  parameter int unsigned MAX_ELEMENTS = vra_pkg::MaxElementsDef
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic        [3:0]  in_req_type,
  input  wire logic signed [31:0] in_operand_value,
  input  wire logic        [5:0]  in_first_position,
  input  wire logic        [5:0]  in_second_position,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed      [38:0] out_result_value,
  output logic             [1:0]  out_status,
  output logic                    out_last_flag,
  input  wire logic               cfg_psel,
  input  wire logic               cfg_penable,
  input  wire logic               cfg_pwrite,
  input  wire logic        [2:0]  cfg_paddr,
  input  wire logic        [31:0] cfg_pwdata,
  output logic             [31:0] cfg_prdata,
  output logic                    cfg_pready
);

  localparam int unsigned AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;

  // configuration register
  logic [6:0] len_r;
  logic [6:0] n;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == vra_pkg::REG_ADDR_LEN) ? {25'd0, len_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= 7'd64;
    end else if (cfg_psel && cfg_penable && cfg_pwrite
                 && (cfg_paddr == vra_pkg::REG_ADDR_LEN)) begin
      len_r <= cfg_pwdata[6:0];
    end
  end

  // length in use, clamped to 1..MAX_ELEMENTS
  always_comb begin
    if (len_r == 7'd0) begin
      n = 7'd1;
    end else if (len_r > 7'(MAX_ELEMENTS)) begin
      n = 7'(MAX_ELEMENTS);
    end else begin
      n = len_r;
    end
  end

  vra_pkg::ctl_state_t st_r, st_nxt;
  logic [3:0]  op_r, op_nxt;
  logic [31:0] opv_r, opv_nxt;
  logic [5:0]  p2_r, p2_nxt;
  logic [6:0]  rd_idx_r, rd_idx_nxt;
  logic [6:0]  proc_idx_r, proc_idx_nxt;
  logic        pend_r, pend_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [31:0] a_r, a_nxt;
  logic [38:0] res_val_r, res_val_nxt;
  logic [1:0]  res_st_r, res_st_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [38:0] out_val_r, out_val_nxt;
  logic [1:0]  out_st_r, out_st_nxt;
  logic        out_last_r, out_last_nxt;
  logic        slot_free;

  // store ports
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [31:0]   mem_wdata, mem_rdata;
  logic [31:0]   prod;
  logic [6:0]    rev_addr;
  logic          accept;

  vra_pkg::div_req_t div_req;
  vra_pkg::div_rsp_t div_rsp;

  vra_mem #(.DEPTH(MAX_ELEMENTS), .AW(AW)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  vra_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign in_ready  = (st_r == vra_pkg::S_IDLE);
  assign accept    = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;

  // one shared multiplier: product reduction or scalar multiply
  assign prod = mem_rdata * ((op_r == vra_pkg::OP_PROD) ? acc_r : opv_r);

  always_comb begin
    st_nxt        = st_r;
    op_nxt        = op_r;
    opv_nxt       = opv_r;
    p2_nxt        = p2_r;
    rd_idx_nxt    = rd_idx_r;
    proc_idx_nxt  = proc_idx_r;
    pend_nxt      = 1'b0;
    acc_nxt       = acc_r;
    a_nxt         = a_r;
    res_val_nxt   = res_val_r;
    res_st_nxt    = res_st_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_val_nxt   = out_val_r;
    out_st_nxt    = out_st_r;
    out_last_nxt  = out_last_r;
    mem_we        = 1'b0;
    mem_waddr     = '0;
    mem_wdata     = '0;
    mem_re        = 1'b0;
    mem_raddr     = '0;
    div_req       = '0;
    rev_addr      = n - 7'd1 - rd_idx_r;

    unique case (st_r)
      vra_pkg::S_IDLE: begin
        if (accept) begin
          op_nxt      = in_req_type;
          opv_nxt     = in_operand_value;
          p2_nxt      = in_second_position;
          rd_idx_nxt  = '0;
          res_val_nxt = '0;
          res_st_nxt  = vra_pkg::ST_OK;
          st_nxt      = vra_pkg::S_RES;
          priority case (in_req_type)
            vra_pkg::OP_LOAD: begin
              if ({1'b0, in_first_position} >= n) begin
                res_st_nxt = vra_pkg::ST_BADPOS;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = in_first_position[AW-1:0];
                mem_wdata = in_operand_value;
              end
            end
            vra_pkg::OP_SUM, vra_pkg::OP_NEGSUM, vra_pkg::OP_ADDS, vra_pkg::OP_MULS: begin
              acc_nxt = '0;
              st_nxt  = vra_pkg::S_WALK;
            end
            vra_pkg::OP_PROD: begin
              acc_nxt = 32'd1;
              st_nxt  = vra_pkg::S_WALK;
            end
            vra_pkg::OP_DIV: begin
              if ({1'b0, in_first_position} >= n || {1'b0, in_second_position} >= n) begin
                res_st_nxt = vra_pkg::ST_BADPOS;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = in_first_position[AW-1:0];
                st_nxt    = vra_pkg::S_DA;
              end
            end
            vra_pkg::OP_RDFWD, vra_pkg::OP_RDREV: begin
              // first element read issued now
              mem_re     = 1'b1;
              mem_raddr  = (in_req_type == vra_pkg::OP_RDREV) ? 
                           AW'(n - 7'd1) : '0;
              rd_idx_nxt = 7'd1;
              st_nxt     = vra_pkg::S_PUT;
            end
            default: begin
              res_st_nxt = vra_pkg::ST_BADOP;
            end
          endcase
        end
      end

      vra_pkg::S_WALK: begin
        // element read last cycle is at mem_rdata
        if (pend_r) begin
          priority case (op_r)
            vra_pkg::OP_SUM:    acc_nxt = acc_r + mem_rdata;
            vra_pkg::OP_NEGSUM: acc_nxt = acc_r - mem_rdata;
            vra_pkg::OP_PROD:   acc_nxt = prod;
            vra_pkg::OP_ADDS: begin
              mem_we    = 1'b1;
              mem_waddr = proc_idx_r[AW-1:0];
              mem_wdata = mem_rdata + opv_r;
            end
            default: begin
              mem_we    = 1'b1;
              mem_waddr = proc_idx_r[AW-1:0];
              mem_wdata = prod;
            end
          endcase
        end
        if (rd_idx_r < n) begin
          mem_re       = 1'b1;
          mem_raddr    = rd_idx_r[AW-1:0];
          proc_idx_nxt = rd_idx_r;
          rd_idx_nxt   = rd_idx_r + 7'd1;
          pend_nxt     = 1'b1;
        end else if (!pend_r) begin
          if (op_r == vra_pkg::OP_ADDS || op_r == vra_pkg::OP_MULS) begin
            res_val_nxt = '0;
          end else begin
            res_val_nxt = {{7{acc_r[31]}}, acc_r};
          end
          st_nxt = vra_pkg::S_RES;
        end
      end

      vra_pkg::S_PUT: begin
        // readout word waits in mem_rdata until the result register is free
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_val_nxt   = {{7{mem_rdata[31]}}, mem_rdata};
          out_st_nxt    = vra_pkg::ST_OK;
          out_last_nxt  = (rd_idx_r == n);
          if (rd_idx_r < n) begin
            mem_re     = 1'b1;
            mem_raddr  = (op_r == vra_pkg::OP_RDREV) ? rev_addr[AW-1:0] : rd_idx_r[AW-1:0];
            rd_idx_nxt = rd_idx_r + 7'd1;
          end else begin
            st_nxt = vra_pkg::S_IDLE;
          end
        end
      end

      vra_pkg::S_DA: begin
        a_nxt     = mem_rdata;
        mem_re    = 1'b1;
        mem_raddr = p2_r[AW-1:0];
        st_nxt    = vra_pkg::S_DB;
      end

      vra_pkg::S_DB: begin
        if (mem_rdata == 32'd0) begin
          res_st_nxt = vra_pkg::ST_DIVZERO;
          st_nxt     = vra_pkg::S_RES;
        end else begin
          div_req.start    = 1'b1;
          div_req.dividend = a_r;
          div_req.divisor  = mem_rdata;
          st_nxt           = vra_pkg::S_DV;
        end
      end

      vra_pkg::S_DV: begin
        if (div_rsp.done) begin
          res_val_nxt = div_rsp.quotient;
          st_nxt      = vra_pkg::S_RES;
        end
      end

      vra_pkg::S_RES: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_val_nxt   = res_val_r;
          out_st_nxt    = res_st_r;
          out_last_nxt  = 1'b1;
          st_nxt        = vra_pkg::S_IDLE;
        end
      end

      default: st_nxt = vra_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= vra_pkg::S_IDLE;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
      pend_r      <= pend_nxt;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    opv_r      <= opv_nxt;
    p2_r       <= p2_nxt;
    rd_idx_r   <= rd_idx_nxt;
    proc_idx_r <= proc_idx_nxt;
    acc_r      <= acc_nxt;
    a_r        <= a_nxt;
    res_val_r  <= res_val_nxt;
    res_st_r   <= res_st_nxt;
    out_val_r  <= out_val_nxt;
    out_st_r   <= out_st_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_result_value = out_val_r;
  assign out_status       = out_st_r;
  assign out_last_flag    = out_last_r;

  // divider is never started on a zero divisor
  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> (div_req.divisor != 32'd0))
    else $error("divider started with zero divisor");

  // writes during a walk stay inside the length in use
  a_walk_wr_range: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == vra_pkg::S_WALK && mem_we) |-> (proc_idx_r < n))
    else $error("element write past length");

  // a word without the last mark only comes from a readout
  a_last_only_readout: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) && !out_last_r |-> $past(st_r == vra_pkg::S_PUT))
    else $error("unmarked word outside readout");

  // nothing is accepted while a walk or divide is under way
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == vra_pkg::S_WALK || st_r == vra_pkg::S_DV) |-> !in_ready)
    else $error("request accepted while busy");

endmodule
`default_nettype wire

// File: dv/vector_register_alu_top_tb.sv
// self-checking testbench for the vector register alu top level
`timescale 1ns / 1ps
module vector_register_alu_top_tb;

  // opcodes above the last real one are all rejected
  localparam logic [3:0] OP_BAD_LO = 4'd9;
  localparam logic [3:0] OP_BAD_HI = 4'd15;
  localparam int MaxElems = 64;
  localparam int unsigned CycleLimit = 2000000;
  localparam int unsigned RandItemsPerPhase = 28;
  localparam int NumPhases = 8;

  // one result word as seen on the output side
  typedef struct packed {
    logic signed [38:0] val;
    logic        [1:0]  st;
    logic               last;
  } alu_word_t;

  // directed stimulus row; chk marks a row whose answer is typed in
  typedef struct {
    logic        [3:0]  op;
    logic signed [31:0] opv;
    logic        [5:0]  p1;
    logic        [5:0]  p2;
    bit                 chk;
    logic signed [38:0] val;
    logic        [1:0]  st;
  } req_row_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic        [3:0]  in_req_type;
  logic signed [31:0] in_operand_value;
  logic        [5:0]  in_first_position;
  logic        [5:0]  in_second_position;
  logic               out_valid;
  logic               out_ready;
  logic signed [38:0] out_result_value;
  logic        [1:0]  out_status;
  logic               out_last_flag;
  logic               cfg_psel;
  logic               cfg_penable;
  logic               cfg_pwrite;
  logic        [2:0]  cfg_paddr;
  logic        [31:0] cfg_pwdata;
  logic        [31:0] cfg_prdata;
  logic               cfg_pready;

  vector_register_alu_top u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_req_type        (in_req_type),
    .in_operand_value   (in_operand_value),
    .in_first_position  (in_first_position),
    .in_second_position (in_second_position),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_result_value   (out_result_value),
    .out_status         (out_status),
    .out_last_flag      (out_last_flag),
    .cfg_psel           (cfg_psel),
    .cfg_penable        (cfg_penable),
    .cfg_pwrite         (cfg_pwrite),
    .cfg_paddr          (cfg_paddr),
    .cfg_pwdata         (cfg_pwdata),
    .cfg_prdata         (cfg_prdata),
    .cfg_pready         (cfg_pready)
  );

  // model of the element store and the length register
  logic [31:0] elem_shadow [MaxElems];
  bit          elem_loaded [MaxElems];
  logic [6:0]  len_shadow;

  // words still owed by the block, oldest first
  alu_word_t   owed_words[$];
  alu_word_t   fresh_words[$];

  int unsigned err_count;
  int unsigned words_checked;
  int unsigned reqs_sent;
  int unsigned cycle_count;
  // 0 no idling, 1 sender idles, 2 receiver stalls, 3 both
  int          idle_mode;

  // clock, and a watchdog on the cycle count
  initial begin
    clk = 1'b0;
    forever begin
      #5 clk = ~clk;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("vector_register_alu_top regression: fail");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    err_count++;
    $display("[%0t] mismatch %s: got %0h want %0h", $realtime, what, got, want);
  endtask

  // lengths outside 1..64 are clamped to that range
  function automatic int live_length();
    if (len_shadow == 7'd0) return 1;
    if (len_shadow > 7'd64) return MaxElems;
    return int'(len_shadow);
  endfunction

  function automatic alu_word_t mk_word(input logic signed [38:0] v, input logic [1:0] s,
                                        input logic l);
    alu_word_t w;
    w.val = v;
    w.st = s;
    w.last = l;
    return w;
  endfunction

  // works out the words one request yields and updates the store model
  task automatic predict_alu_request(input logic [3:0] op, input logic signed [31:0] opv,
                                     input logic [5:0] p1, input logic [5:0] p2);
    int          n;
    logic [31:0] acc;
    logic [31:0] a;
    logic [31:0] b;
    logic [63:0] ma;
    logic [63:0] mb;
    logic [63:0] q;
    logic signed [31:0] sv;
    n = live_length();
    fresh_words.delete();
    case (op)
      vra_pkg::OP_LOAD: begin
        if (p1 >= n) begin
          fresh_words.push_back(mk_word('0, vra_pkg::ST_BADPOS, 1'b1));
        end else begin
          elem_shadow[p1] = opv;
          elem_loaded[p1] = 1'b1;
          fresh_words.push_back(mk_word('0, vra_pkg::ST_OK, 1'b1));
        end
      end
      vra_pkg::OP_SUM, vra_pkg::OP_NEGSUM, vra_pkg::OP_PROD: begin
        acc = (op == vra_pkg::OP_PROD) ? 32'd1 : 32'd0;
        for (int i = 0; i < n; i++) begin
          if (op == vra_pkg::OP_SUM) acc = acc + elem_shadow[i];
          else if (op == vra_pkg::OP_NEGSUM) acc = acc - elem_shadow[i];
          else acc = acc * elem_shadow[i];
        end
        sv = $signed(acc);
        fresh_words.push_back(mk_word(39'(sv), vra_pkg::ST_OK, 1'b1));
      end
      vra_pkg::OP_DIV: begin
        if (p1 >= n || p2 >= n) begin
          fresh_words.push_back(mk_word('0, vra_pkg::ST_BADPOS, 1'b1));
        end else if (elem_shadow[p2] == 32'd0) begin
          fresh_words.push_back(mk_word('0, vra_pkg::ST_DIVZERO, 1'b1));
        end else begin
          a = elem_shadow[p1];
          b = elem_shadow[p2];
          ma = a[31] ? (64'h1_0000_0000 - {32'd0, a}) : {32'd0, a};
          mb = b[31] ? (64'h1_0000_0000 - {32'd0, b}) : {32'd0, b};
          // round half away from zero on the magnitudes
          q = (64'd200 * ma + mb) / (64'd2 * mb);
          if (a[31] ^ b[31]) q = -q;
          fresh_words.push_back(mk_word(q[38:0], vra_pkg::ST_OK, 1'b1));
        end
      end
      vra_pkg::OP_ADDS, vra_pkg::OP_MULS: begin
        for (int i = 0; i < n; i++) begin
          if (op == vra_pkg::OP_ADDS) elem_shadow[i] = elem_shadow[i] + opv;
          else elem_shadow[i] = elem_shadow[i] * opv;
        end
        fresh_words.push_back(mk_word('0, vra_pkg::ST_OK, 1'b1));
      end
      vra_pkg::OP_RDFWD, vra_pkg::OP_RDREV: begin
        for (int i = 0; i < n; i++) begin
          sv = $signed(elem_shadow[(op == vra_pkg::OP_RDFWD) ? i : n - 1 - i]);
          fresh_words.push_back(mk_word(39'(sv), vra_pkg::ST_OK, i == n - 1));
        end
      end
      default: begin
        fresh_words.push_back(mk_word('0, vra_pkg::ST_BADOP, 1'b1));
      end
    endcase
  endtask

  // drives one request and holds it until taken; prediction at acceptance
  task automatic send_request(input req_row_t r);
    if (idle_mode == 1 || idle_mode == 3) begin
      while ($urandom_range(0, 99) < ((idle_mode == 1) ? 79 : 26)) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
    end
    in_valid <= 1'b1;
    in_req_type <= r.op;
    in_operand_value <= r.opv;
    in_first_position <= r.p1;
    in_second_position <= r.p2;
    do @(posedge clk); while (!(in_valid && in_ready));
    predict_alu_request(r.op, r.opv, r.p1, r.p2);
    reqs_sent++;
    if (r.chk) begin
      owed_words.push_back(mk_word(r.val, r.st, 1'b1));
    end else begin
      foreach (fresh_words[i]) owed_words.push_back(fresh_words[i]);
    end
    // valid stays high into the next request unless an idle gap or the drain drops it
    @(negedge clk);
  endtask

  // waits until every owed word has come back, then a short settle
  task automatic drain_results();
    in_valid <= 1'b0;
    while (owed_words.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  // apb write: setup then access, register updates at the access edge
  task automatic write_length(input logic [6:0] len);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= vra_pkg::REG_ADDR_LEN;
    cfg_pwdata <= {25'd0, len};
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    len_shadow = len;
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  // receiver: random stall pattern per phase, set on the falling edge
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (idle_mode == 2) out_ready <= ($urandom_range(0, 99) >= 79);
      else if (idle_mode == 3) out_ready <= ($urandom_range(0, 99) >= 26);
      else out_ready <= 1'b1;
    end
  end

  // result checker, sampled at the rising edge
  always @(posedge clk) begin
    alu_word_t want;
    if (rst_n && out_valid && out_ready) begin
      if (owed_words.size() == 0) begin
        report_mismatch("unexpected word", out_result_value, 0);
      end else begin
        want = owed_words.pop_front();
        words_checked++;
        if (out_result_value !== want.val)
          report_mismatch("result_value", out_result_value, want.val);
        if (out_status !== want.st)
          report_mismatch("status", out_status, want.st);
        if (out_last_flag !== want.last)
          report_mismatch("last_flag", out_last_flag, want.last);
      end
    end
  end

  // first element in use that was never loaded, or -1
  function automatic int first_unloaded(input int n);
    for (int i = 0; i < n; i++) if (!elem_loaded[i]) return i;
    return -1;
  endfunction

  // random request; anything that would read an unloaded element becomes a load of it instead
  function automatic req_row_t random_request();
    req_row_t r;
    int       n;
    int       pick;
    int       hole;
    n = live_length();
    pick = $urandom_range(0, 99);
    r.chk = 1'b0;
    r.val = '0;
    r.st = vra_pkg::ST_OK;
    r.opv = $urandom();
    r.p1 = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 63))
                                       : 6'($urandom_range(0, n - 1));
    r.p2 = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 63))
                                       : 6'($urandom_range(0, n - 1));
    if (pick < 30) r.op = vra_pkg::OP_LOAD;
    else if (pick < 38) r.op = vra_pkg::OP_SUM;
    else if (pick < 44) r.op = vra_pkg::OP_NEGSUM;
    else if (pick < 50) r.op = vra_pkg::OP_PROD;
    else if (pick < 66) r.op = vra_pkg::OP_DIV;
    else if (pick < 74) r.op = vra_pkg::OP_ADDS;
    else if (pick < 80) r.op = vra_pkg::OP_MULS;
    else if (pick < 87) r.op = vra_pkg::OP_RDFWD;
    else if (pick < 94) r.op = vra_pkg::OP_RDREV;
    else r.op = 4'($urandom_range(OP_BAD_LO, OP_BAD_HI));
    // keep multiply-scalar from zeroing the vector too often
    if (r.op == vra_pkg::OP_MULS && $urandom_range(0, 3) != 0)
      r.opv = $signed($urandom_range(0, 6)) - 3;
    hole = first_unloaded(n);
    if (r.op == vra_pkg::OP_DIV) begin
      if (r.p1 < n && r.p2 < n) begin
        if (!elem_loaded[r.p1]) hole = r.p1;
        else if (!elem_loaded[r.p2]) hole = r.p2;
        else hole = -1;
      end else begin
        hole = -1;
      end
    end
    if (hole >= 0 && r.op != vra_pkg::OP_LOAD && r.op <= vra_pkg::OP_RDREV) begin
      r.op = vra_pkg::OP_LOAD;
      r.p1 = 6'(hole);
    end
    return r;
  endfunction

  // directed rows: length 4 is set before these run
  req_row_t dir_rows[] = '{
    '{vra_pkg::OP_LOAD,   32'sh7fffffff, 6'd0,  6'd0,  0, 39'sd0, vra_pkg::ST_OK},
    '{vra_pkg::OP_LOAD,   32'sh80000000, 6'd1,  6'd0,  0, 39'sd0, vra_pkg::ST_OK},
    '{vra_pkg::OP_LOAD,   -32'sd1,       6'd2,  6'd63, 0, 39'sd0, vra_pkg::ST_OK},
    '{vra_pkg::OP_LOAD,   32'sd0,        6'd3,  6'd0,  0, 39'sd0, vra_pkg::ST_OK},
    // loads past the length are refused
    '{vra_pkg::OP_LOAD,   32'sd5,        6'd4,  6'd0,  1, 39'sd0, vra_pkg::ST_BADPOS},
    '{vra_pkg::OP_LOAD,   -32'sd1,       6'd63, 6'd63, 1, 39'sd0, vra_pkg::ST_BADPOS},
    '{vra_pkg::OP_DIV,    32'sd0,        6'd0,  6'd3,  1, 39'sd0, vra_pkg::ST_DIVZERO},
    // position check wins over the zero divisor
    '{vra_pkg::OP_DIV,    32'sd0,        6'd5,  6'd3,  1, 39'sd0, vra_pkg::ST_BADPOS},
    '{vra_pkg::OP_DIV,    32'sd0,        6'd0,  6'd63, 1, 39'sd0, vra_pkg::ST_BADPOS},
    '{vra_pkg::OP_SUM,    32'sd0,        6'd0,  6'd0,  0, 39'sd0, vra_pkg::ST_OK},
    '{vra_pkg::OP_NEGSUM, 32'sd0,        6'd0,  6'd0,  0, 39'sd0, vra_pkg::ST_OK},
    '{vra_pkg::OP_PROD,   32'sd0,        6'd0,  6'd0,  0, 39'sd0, vra_pkg::ST_OK},
    '{vra_pkg::OP_DIV,    32'sd0,        6'd1,  6'd2,  0, 39'sd0, vra_pkg::ST_OK},
    '{vra_pkg::OP_DIV,    32'sd0,        6'd0,  6'd1,  0, 39'sd0, vra_pkg::ST_OK},
    '{vra_pkg::OP_DIV,    32'sd0,        6'd1,  6'd0,  0, 39'sd0, vra_pkg::ST_OK},
    '{vra_pkg::OP_RDFWD,  32'sd0,        6'd0,  6'd0,  0, 39'sd0, vra_pkg::ST_OK},
    '{vra_pkg::OP_ADDS,   32'sd1,        6'd0,  6'd0,  1, 39'sd0, vra_pkg::ST_OK},
    '{vra_pkg::OP_MULS,   -32'sd1,       6'd0,  6'd0,  1, 39'sd0, vra_pkg::ST_OK},
    '{vra_pkg::OP_RDREV,  32'sd0,        6'd0,  6'd0,  0, 39'sd0, vra_pkg::ST_OK},
    '{vra_pkg::OP_PROD,   32'sd0,        6'd0,  6'd0,  0, 39'sd0, vra_pkg::ST_OK},
    '{OP_BAD_LO,          32'sh7fffffff, 6'd63, 6'd63, 1, 39'sd0, vra_pkg::ST_BADOP},
    '{OP_BAD_HI,          32'sh80000000, 6'd0,  6'd0,  1, 39'sd0, vra_pkg::ST_BADOP},
    // a divide that rounds: 7 / 3 -> 233
    '{vra_pkg::OP_LOAD,   32'sd7,        6'd3,  6'd0,  0, 39'sd0, vra_pkg::ST_OK},
    '{vra_pkg::OP_LOAD,   32'sd3,        6'd2,  6'd0,  0, 39'sd0, vra_pkg::ST_OK},
    '{vra_pkg::OP_DIV,    32'sd0,        6'd3,  6'd2,  1, 39'sd233, vra_pkg::ST_OK}
  };

  // lengths per phase, extremes and out-of-range codes among them
  logic [6:0] phase_len [NumPhases] = '{7'd64, 7'd1, 7'd127, 7'd0, 7'd17, 7'd3, 7'd50, 7'd8};

  initial begin
    cycle_count = 0;
    err_count = 0;
    words_checked = 0;
    reqs_sent = 0;
    idle_mode = 0;
    len_shadow = 7'd64;
    foreach (elem_shadow[i]) begin
      elem_shadow[i] = '0;
      elem_loaded[i] = 1'b0;
    end
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_req_type = '0;
    in_operand_value = '0;
    in_first_position = '0;
    in_second_position = '0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed part on a short vector
    write_length(7'd4);
    foreach (dir_rows[i]) send_request(dir_rows[i]);
    drain_results();

    // random phases, each with its own length and idle pattern
    for (int ph = 0; ph < NumPhases; ph++) begin
      idle_mode = ph % 4;
      write_length(phase_len[ph]);
      for (int k = 0; k < RandItemsPerPhase; k++) send_request(random_request());
      drain_results();
    end

    // settle with the receiver always ready
    idle_mode = 0;
    repeat (200) @(posedge clk);
    $display("covered %0d requests and %0d result words over %0d length settings",
             reqs_sent, words_checked, NumPhases + 1);
    $display("idle patterns: none, sender gaps, receiver stalls, both; mismatches %0d",
             err_count);
    if (err_count == 0 && owed_words.size() == 0) begin
      $display("vector_register_alu_top regression: pass");
    end else begin
      $display("vector_register_alu_top regression: fail");
    end
    $finish;
  end

endmodule

// File: filelist.f
src/vra_pkg.sv
src/vra_mem.sv
src/vra_div.sv
src/vector_register_alu_top.sv
dv/vector_register_alu_top_tb.sv
